### hdl/pcdf_pkg.sv
// Shared types and constants for the pid capability dedup filter.
package pcdf_pkg;

   localparam int BUCKETS     = 2048;
   localparam int SLOT_W      = $clog2(BUCKETS);
   localparam int PID_W       = 32;
   localparam int TIME_W      = 32;
   localparam int CAPNUM_W    = 8;
   localparam int CAPS_W      = 64;
   localparam int CAP_W       = $clog2(CAPS_W);
   localparam logic [CAPNUM_W-1:0] CAP_LIMIT = CAPNUM_W'(CAPS_W);
   localparam logic [TIME_W-1:0]   WINDOW_RESET = TIME_W'(60);

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 8;

   // queue depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [CAPS_W-1:0] caps;
      logic [TIME_W-1:0] start;
      logic [PID_W-1:0]  owner;
   } bucket_type;

   localparam int BUCKET_W = $bits(bucket_type);

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [CAP_W-1:0]  cap;
      logic [TIME_W-1:0] now;
      logic              bypass;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } back_state_type;

endpackage

### hdl/pcdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pcdf_front.sv
// Front part: accepts request words, classifies them and queues them for the back part.
module pcdf_front
   import pcdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  back_ctl_type          back_ctl,
   output queue_head_type        head
);

   item_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push;
   item_type               item_new;

   // classify: capabilities beyond the bitmap skip the table
   always_comb begin
      item_new.pid    = req_tdata[31:0];
      item_new.cap    = req_tdata[32 +: CAP_W];
      item_new.now    = req_tdata[71:40];
      item_new.bypass = req_tdata[39:32] >= CAP_LIMIT;
   end

   assign req_tready = !back_ctl.clearing &&
                       (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push        ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = back_ctl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !back_ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && back_ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

### hdl/pcdf_back.sv
// Back part: clears the bucket table, then runs one read-modify-write per table word.
module pcdf_back
   import pcdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TIME_W-1:0]     csr_wr_data,
   input  queue_head_type        head,
   output back_ctl_type          back_ctl,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   back_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] clear_addr_ff, clear_addr_in;
   item_type          cur_ff;
   logic [TIME_W-1:0] window_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_supp_ff, rsp_supp_in;

   logic              out_free;
   logic              pop;
   logic              rd_en;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   bucket_type        wr_bucket;
   bucket_type        rd_bucket;
   bucket_type        upd_bucket;
   logic              expired;
   logic              rebind;
   logic [CAPS_W-1:0] caps_base;
   logic [CAPS_W-1:0] cap_bit;
   logic              hit;
   logic              exec_done;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // pop: table words always go to the read, bypass words need a free output
   assign pop   = (state_ff == ST_IDLE) && head.valid && (!head.item.bypass || out_free);
   assign rd_en = pop && !head.item.bypass;
   assign exec_done = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      expired   = (rd_bucket.start != '0) &&
                  ((cur_ff.now - rd_bucket.start) >= window_ff);
      rebind    = (rd_bucket.owner != cur_ff.pid) || expired;
      caps_base = rebind ? '0 : rd_bucket.caps;
      cap_bit   = CAPS_W'(1) << cur_ff.cap;
      hit       = |(caps_base & cap_bit);
      upd_bucket.owner = cur_ff.pid;
      upd_bucket.start = rebind ? cur_ff.now : rd_bucket.start;
      upd_bucket.caps  = caps_base | cap_bit;
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en     = 1'b1;
         wr_addr   = clear_addr_ff;
         wr_bucket = '0;
      end else begin
         wr_en     = exec_done;
         wr_addr   = cur_ff.pid[SLOT_W-1:0];
         wr_bucket = upd_bucket;
      end
   end

   pcdf_ram #(
      .WIDTH (BUCKET_W),
      .DEPTH (BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_bucket),
      .rd_en   (rd_en),
      .rd_addr (head.item.pid[SLOT_W-1:0]),
      .rd_data (rd_bucket)
   );

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == SLOT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (rd_en) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the output register frees up
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_supp_in  = rsp_supp_ff;
      if (pop && head.item.bypass) begin
         rsp_valid_in = 1'b1;
         rsp_supp_in  = 1'b0;
      end else if (exec_done) begin
         rsp_valid_in = 1'b1;
         rsp_supp_in  = hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         window_ff     <= WINDOW_RESET;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_supp_ff <= rsp_supp_in;
      if (pop) begin
         cur_ff <= head.item;
      end
   end

   assign back_ctl.pop      = pop;
   assign back_ctl.clearing = state_ff == ST_CLEAR;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), rsp_supp_ff};

endmodule

### hdl/pid_capability_dedup_filter_top.sv
// Top level of the pid capability dedup filter.
//
//  channel  | direction | word
//  ---------+-----------+------------------------------------------------
//  req_     | in        | tdata: pid[31:0], capability[39:32], now_seconds[71:40]
//  rsp_     | out       | tdata: suppressed[0], zeros[7:1]
//  csr_     | in        | wr_data: window_seconds[31:0]
//
// A word with a capability below 64 takes a bucket read, then compare and write
// back (held while the result register is stalled), through the one read and one
// write port of the bucket RAM. A word with a larger capability skips the RAM and
// goes straight to the result register. Words are queued in registers first. After
// reset, a clearing pass writes all 2048 buckets, one per cycle, with req_tready low.
// A stalled rsp_ side holds the result register; the queue takes words until full.
module pid_capability_dedup_filter_top
   import pcdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pid, capability, now_seconds
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // suppressed, zero pad
   input  logic                  csr_wr_en,
   input  logic [TIME_W-1:0]     csr_wr_data
);

   queue_head_type head;
   back_ctl_type   back_ctl;

   pcdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .back_ctl   (back_ctl),
      .head       (head)
   );

   pcdf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .back_ctl    (back_ctl),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### hdl/pcdf_checker.sv
// Port-level checks for the pid capability dedup filter, bound to the top level.
module pcdf_checker
   import pcdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // the clearing pass blocks input right after reset
   a_clear_blocks_input: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high in the cycle after reset");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:1] == '0)
      else $error("result padding not zero");

endmodule

bind pid_capability_dedup_filter_top pcdf_checker u_checker (.*);
